FILE: rtl/bfpu_pkg.sv
// ----------------------------------------------------------------------------
// bfpu_pkg
// Shared types, codes and helpers of the bit field packer and unpacker.
// ----------------------------------------------------------------------------
package bfpu_pkg;

  localparam int unsigned WORD_W           = 32;
  localparam int unsigned SCRATCH_W        = 64;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned WIDTH_W          = 6;
  localparam int unsigned FUNC_W           = 3;
  localparam int unsigned ADDR_OUT_W       = 8;
  localparam int unsigned BITS_W           = 32;
  localparam int unsigned BYTE_BITS        = 8;
  localparam int unsigned BUFFER_WORDS_DEF = 256;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE       = 3'd0,
    FN_WRITE_ALIGN = 3'd1,
    FN_FLUSH       = 3'd2,
    FN_REWIND      = 3'd3,
    FN_READ        = 3'd4,
    FN_READ_ALIGN  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_READ_PAST = 2'd1,
    ST_PADDING  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [WORD_W-1:0]  data_in;
    logic [WIDTH_W-1:0] bit_count;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]     read_value;
    status_e               status;
    logic                  word_valid;
    logic [WORD_W-1:0]     word_out;
    logic [ADDR_OUT_W-1:0] word_addr;
  } result_t;

  // widths above one word count as one word
  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] n);
    logic [WIDTH_W-1:0] r;
    r = (n > WIDTH_W'(WORD_W)) ? WIDTH_W'(WORD_W) : n;
    return r;
  endfunction

  // all ones for a full word field
  function automatic logic [WORD_W-1:0] low_mask(input logic [WIDTH_W-1:0] n);
    logic [WORD_W-1:0] m;
    if (n >= WIDTH_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << n) - WORD_W'(1);
    end
    return m;
  endfunction

endpackage

FILE: rtl/bfpu_ram.sv
// ----------------------------------------------------------------------------
// bfpu_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bfpu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bfpu_step.sv
// ----------------------------------------------------------------------------
// bfpu_step
// Single pass datapath: applies one transaction to the packer state and
// forms its result.
// ----------------------------------------------------------------------------
module bfpu_step import bfpu_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = BUFFER_WORDS_DEF,
  localparam int unsigned PtrW  = $clog2(BUFFER_WORDS + 1),
  localparam int unsigned ConsW = $clog2(BUFFER_WORDS * WORD_W + 1)
) (
  input  item_t                item_i,
  input  logic [SCRATCH_W-1:0] scratch_i,
  input  logic [CNT_W-1:0]     cnt_i,
  input  logic [PtrW-1:0]      wp_i,
  input  logic [BITS_W-1:0]    written_i,
  input  logic [ConsW-1:0]     consumed_i,
  input  logic [WORD_W-1:0]    mem_data_i,
  output logic [SCRATCH_W-1:0] scratch_o,
  output logic [CNT_W-1:0]     cnt_o,
  output logic [PtrW-1:0]      wp_o,
  output logic [BITS_W-1:0]    written_o,
  output logic [ConsW-1:0]     consumed_o,
  output result_t              res_o
);

  logic [WIDTH_W-1:0] n;
  logic [WIDTH_W-1:0] align_w;
  logic [WIDTH_W-1:0] align_r;
  logic               wp_full;

  // pack side
  logic [WIDTH_W-1:0]   wr_n;
  logic [WORD_W-1:0]    wr_val;
  logic [CNT_W-1:0]     pk_sum;
  logic                 pk_need;
  logic                 pk_refuse;
  logic [SCRATCH_W-1:0] pk_merged;

  // unpack side
  logic [WIDTH_W-1:0]   rd_n;
  logic                 up_past;
  logic                 up_need;
  logic [SCRATCH_W-1:0] up_s;
  logic [CNT_W-1:0]     up_cnt;
  logic [WORD_W-1:0]    up_val;

  assign n       = clamp_width(item_i.bit_count);
  assign align_w = WIDTH_W'(BYTE_BITS) - {3'b000, written_i[2:0]};
  assign align_r = WIDTH_W'(BYTE_BITS) - {3'b000, consumed_i[2:0]};
  assign wp_full = (wp_i >= PtrW'(BUFFER_WORDS));

  assign wr_n      = (func_e'(item_i.func) == FN_WRITE_ALIGN) ? align_w : n;
  assign wr_val    = (func_e'(item_i.func) == FN_WRITE_ALIGN) ? '0 : item_i.data_in;
  assign pk_sum    = cnt_i + CNT_W'(wr_n);
  assign pk_need   = (pk_sum > CNT_W'(WORD_W));
  assign pk_refuse = (pk_sum > CNT_W'(SCRATCH_W)) || (pk_need && wp_full);
  assign pk_merged = scratch_i | ({{WORD_W{1'b0}}, wr_val & low_mask(wr_n)} << cnt_i);

  assign rd_n    = (func_e'(item_i.func) == FN_READ_ALIGN) ? align_r : n;
  assign up_past = ((BITS_W + 1)'(consumed_i) + (BITS_W + 1)'(rd_n)) >
                   (BITS_W + 1)'(written_i);
  assign up_need = (CNT_W'(rd_n) > cnt_i);
  assign up_s    = up_need ? (scratch_i | ({{WORD_W{1'b0}}, mem_data_i} << cnt_i))
                           : scratch_i;
  assign up_cnt  = cnt_i + (up_need ? CNT_W'(WORD_W) : '0);
  assign up_val  = up_s[WORD_W-1:0] & low_mask(rd_n);

  always_comb begin
    logic do_pack;
    logic do_unpack;
    logic is_align;

    scratch_o  = scratch_i;
    cnt_o      = cnt_i;
    wp_o       = wp_i;
    written_o  = written_i;
    consumed_o = consumed_i;
    res_o      = '0;
    do_pack    = 1'b0;
    do_unpack  = 1'b0;
    is_align   = 1'b0;

    unique case (func_e'(item_i.func))
      FN_WRITE: begin
        do_pack = (n != '0);
      end
      FN_WRITE_ALIGN: begin
        do_pack = (written_i[2:0] != '0);
      end
      FN_FLUSH: begin
        if (cnt_i != '0) begin
          if (wp_full) begin
            res_o.status = ST_FULL;
          end else begin
            res_o.word_valid = 1'b1;
            res_o.word_out   = scratch_i[WORD_W-1:0];
            res_o.word_addr  = ADDR_OUT_W'(wp_i);
            wp_o             = wp_i + PtrW'(1);
            scratch_o        = scratch_i >> WORD_W;
            cnt_o            = (cnt_i > CNT_W'(WORD_W)) ? cnt_i - CNT_W'(WORD_W) : '0;
          end
        end
      end
      FN_REWIND: begin
        scratch_o  = '0;
        cnt_o      = '0;
        wp_o       = '0;
        consumed_o = '0;
      end
      FN_READ: begin
        do_unpack = (n != '0);
      end
      FN_READ_ALIGN: begin
        do_unpack = (consumed_i[2:0] != '0);
        is_align  = 1'b1;
      end
      default: ;
    endcase

    if (do_pack) begin
      if (pk_refuse) begin
        res_o.status = ST_FULL;
      end else begin
        written_o = written_i + BITS_W'(wr_n);
        if (pk_need) begin
          res_o.word_valid = 1'b1;
          res_o.word_out   = pk_merged[WORD_W-1:0];
          res_o.word_addr  = ADDR_OUT_W'(wp_i);
          wp_o             = wp_i + PtrW'(1);
          scratch_o        = pk_merged >> WORD_W;
          cnt_o            = pk_sum - CNT_W'(WORD_W);
        end else begin
          scratch_o = pk_merged;
          cnt_o     = pk_sum;
        end
      end
    end

    if (do_unpack) begin
      if (up_past) begin
        res_o.status = ST_READ_PAST;
      end else if (up_need && wp_full) begin
        res_o.status = ST_FULL;
      end else begin
        scratch_o  = up_s >> rd_n;
        cnt_o      = up_cnt - CNT_W'(rd_n);
        consumed_o = consumed_i + ConsW'(rd_n);
        if (up_need) begin
          wp_o = wp_i + PtrW'(1);
        end
        if (is_align) begin
          res_o.status = (up_val != '0) ? ST_PADDING : ST_OK;
        end else begin
          res_o.read_value = up_val;
        end
      end
    end
  end

endmodule

FILE: rtl/bit_field_packer_unpacker.sv
// ----------------------------------------------------------------------------
// bit_field_packer_unpacker
// Packs fields of 1 to 32 bits into 32-bit words of a word buffer and unpacks
// them again in the same order.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one operation per transaction (func_i,
//   data_in_i, bit_count_i): write, write align, flush, rewind, read or
//   read align. Every input transaction gives exactly one result transaction
//   with read_value_o, status_o and, when a word went into the buffer,
//   word_valid_o, word_out_o and word_addr_o.
//   From input acceptance to result valid the path is one input register,
//   then the shift/mask/count logic into the result register. Throughput
//   is one transaction per cycle while the receiver does not stall, also
//   when a read pulls a fresh word from the buffer: the buffer read port
//   is addressed with the next word pointer while it lies in the buffer,
//   so the word is waiting in its read register.
//   When the receiver stalls, the result register holds and the input
//   register still fills once; in_stall_o rises only when both are full.
//   Reset clears the scratch, counters, pointer and both valid flags at once;
//   buffer contents are undefined until written, no clearing pass is run.
// ----------------------------------------------------------------------------
module bit_field_packer_unpacker import bfpu_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = BUFFER_WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [WORD_W-1:0]     data_in_i,
  input  logic [WIDTH_W-1:0]    bit_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [WORD_W-1:0]     read_value_o,
  output logic [1:0]            status_o,
  output logic                  word_valid_o,
  output logic [WORD_W-1:0]     word_out_o,
  output logic [ADDR_OUT_W-1:0] word_addr_o
);

  localparam int unsigned PtrW  = $clog2(BUFFER_WORDS + 1);
  localparam int unsigned ConsW = $clog2(BUFFER_WORDS * WORD_W + 1);
  localparam int unsigned AddrW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

  logic                 in_valid_q, in_valid_d;
  item_t                item_q;
  logic                 out_valid_q, out_valid_d;
  result_t              res_q;
  result_t              res_d;
  logic                 out_ready;
  logic                 in_accept;
  logic                 fire;

  logic [SCRATCH_W-1:0] scratch_q, scratch_d, scratch_nx;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_nx;
  logic [PtrW-1:0]      wp_q, wp_d, wp_nx;
  logic [BITS_W-1:0]    written_q, written_d, written_nx;
  logic [ConsW-1:0]     consumed_q, consumed_d, consumed_nx;

  logic [WORD_W-1:0]    mem_rdata;
  logic [AddrW-1:0]     mem_raddr;
  logic                 mem_we;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  bfpu_step #(
    .BUFFER_WORDS(BUFFER_WORDS)
  ) u_step (
    .item_i     (item_q),
    .scratch_i  (scratch_q),
    .cnt_i      (cnt_q),
    .wp_i       (wp_q),
    .written_i  (written_q),
    .consumed_i (consumed_q),
    .mem_data_i (mem_rdata),
    .scratch_o  (scratch_nx),
    .cnt_o      (cnt_nx),
    .wp_o       (wp_nx),
    .written_o  (written_nx),
    .consumed_o (consumed_nx),
    .res_o      (res_d)
  );

  always_comb begin
    in_valid_d  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    out_valid_d = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
    scratch_d   = fire ? scratch_nx  : scratch_q;
    cnt_d       = fire ? cnt_nx      : cnt_q;
    wp_d        = fire ? wp_nx       : wp_q;
    written_d   = fire ? written_nx  : written_q;
    consumed_d  = fire ? consumed_nx : consumed_q;
  end

  // read port follows the next pointer so the word is ready for the next read
  assign mem_raddr = (wp_d < PtrW'(BUFFER_WORDS)) ? wp_d[AddrW-1:0] : '0;
  assign mem_we    = fire && res_d.word_valid;

  bfpu_ram #(
    .Width(WORD_W),
    .Depth(BUFFER_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q[AddrW-1:0]),
    .wdata_i (res_d.word_out),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scratch_q   <= '0;
      cnt_q       <= '0;
      wp_q        <= '0;
      written_q   <= '0;
      consumed_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      scratch_q   <= scratch_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      written_q   <= written_d;
      consumed_q  <= consumed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.func      <= func_i;
      item_q.data_in   <= data_in_i;
      item_q.bit_count <= bit_count_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = res_q.read_value;
  assign status_o     = res_q.status;
  assign word_valid_o = res_q.word_valid;
  assign word_out_o   = res_q.word_out;
  assign word_addr_o  = res_q.word_addr;

  // a stored word only comes with a clean status
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_valid_o |-> status_o == ST_OK)
    else $error("word stored with error status");

  // failed operations return no field value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0)
    else $error("value returned with error status");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PtrW'(BUFFER_WORDS))
    else $error("word pointer beyond buffer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SCRATCH_W))
    else $error("scratch bit count beyond scratch width");

  // pointer only moves with a transaction
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(wp_q))
    else $error("word pointer moved without a transaction");

endmodule
